/* rtl/gmdfs_pkg.sv */
// types, codes and control store for the grid maze depth-first search block
// no dependencies; imported by grid_maze_dfs_search_top
`default_nettype none

package gmdfs_pkg;

  // item op codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  // configuration register indexes
  localparam logic CFG_GOAL_X = 1'b0;
  localparam logic CFG_GOAL_Y = 1'b1;

  // move directions, tried in this order
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef logic [4:0] step_t;

  // control store addresses
  localparam step_t S_EMIT      = 5'd0;
  localparam step_t S_IDLE      = 5'd1;
  localparam step_t S_DECODE    = 5'd2;
  localparam step_t S_WR0       = 5'd3;
  localparam step_t S_WR1       = 5'd4;
  localparam step_t S_RD0       = 5'd5;
  localparam step_t S_RD1       = 5'd6;
  localparam step_t S_CLR0      = 5'd7;
  localparam step_t S_CLR1      = 5'd8;
  localparam step_t S_START     = 5'd9;
  localparam step_t S_SEED      = 5'd10;
  localparam step_t S_VISIT     = 5'd11;
  localparam step_t S_PROBE     = 5'd12;
  localparam step_t S_TEST      = 5'd13;
  localparam step_t S_NEXT_DIR  = 5'd14;
  localparam step_t S_POP       = 5'd15;
  localparam step_t S_TOP_RD    = 5'd16;
  localparam step_t S_TOP_LOAD  = 5'd17;
  localparam step_t S_PUSH      = 5'd18;
  localparam step_t S_PUSH_JMP  = 5'd19;
  localparam step_t S_FOUND     = 5'd20;
  localparam step_t S_NOPATH    = 5'd21;
  localparam step_t S_SWEEP     = 5'd22;
  localparam step_t S_SWEEP_END = 5'd23;

  typedef enum logic [4:0] {
    U_NOP        = 5'd0,
    U_EMIT       = 5'd1,
    U_IDLE       = 5'd2,
    U_DECODE     = 5'd3,
    U_WALL_RD    = 5'd4,
    U_WALL_WR    = 5'd5,
    U_STK_RD_IDX = 5'd6,
    U_READ_OUT   = 5'd7,
    U_VIS_SWEEP  = 5'd8,
    U_CLEAR_STK  = 5'd9,
    U_LOAD_START = 5'd10,
    U_SEED       = 5'd11,
    U_VISIT      = 5'd12,
    U_PROBE      = 5'd13,
    U_DIR_INC    = 5'd14,
    U_POP        = 5'd15,
    U_STK_RD_TOP = 5'd16,
    U_LOAD_TOP   = 5'd17,
    U_PUSH       = 5'd18,
    U_SET_FOUND  = 5'd19,
    U_SET_NOPATH = 5'd20,
    U_SWEEP_ALL  = 5'd21
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER        = 4'd0,
    C_ALWAYS       = 4'd1,
    C_OUT_BUSY     = 4'd2,
    C_NO_ACCEPT    = 4'd3,
    C_DISPATCH     = 4'd4,
    C_NOT_LAST     = 4'd5,
    C_HERE_GOAL    = 4'd6,
    C_CAN_MOVE     = 4'd7,
    C_NOT_LAST_DIR = 4'd8,
    C_COUNT_ZERO   = 4'd9,
    C_STACK_FULL   = 4'd10
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // control store: cond jumps to target (dispatch: op routine), else step+1
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    unique case (s)
      S_EMIT:      w = '{U_EMIT,       C_OUT_BUSY,     S_EMIT};
      S_IDLE:      w = '{U_IDLE,       C_NO_ACCEPT,    S_IDLE};
      S_DECODE:    w = '{U_DECODE,     C_DISPATCH,     S_IDLE};
      S_WR0:       w = '{U_WALL_RD,    C_NEVER,        S_IDLE};
      S_WR1:       w = '{U_WALL_WR,    C_ALWAYS,       S_EMIT};
      S_RD0:       w = '{U_STK_RD_IDX, C_NEVER,        S_IDLE};
      S_RD1:       w = '{U_READ_OUT,   C_ALWAYS,       S_EMIT};
      S_CLR0:      w = '{U_VIS_SWEEP,  C_NOT_LAST,     S_CLR0};
      S_CLR1:      w = '{U_CLEAR_STK,  C_ALWAYS,       S_EMIT};
      S_START:     w = '{U_LOAD_START, C_NEVER,        S_IDLE};
      S_SEED:      w = '{U_SEED,       C_HERE_GOAL,    S_FOUND};
      S_VISIT:     w = '{U_VISIT,      C_HERE_GOAL,    S_FOUND};
      S_PROBE:     w = '{U_PROBE,      C_NEVER,        S_IDLE};
      S_TEST:      w = '{U_NOP,        C_CAN_MOVE,     S_PUSH};
      S_NEXT_DIR:  w = '{U_DIR_INC,    C_NOT_LAST_DIR, S_PROBE};
      S_POP:       w = '{U_POP,        C_NEVER,        S_IDLE};
      S_TOP_RD:    w = '{U_STK_RD_TOP, C_COUNT_ZERO,   S_NOPATH};
      S_TOP_LOAD:  w = '{U_LOAD_TOP,   C_ALWAYS,       S_VISIT};
      S_PUSH:      w = '{U_PUSH,       C_STACK_FULL,   S_NOPATH};
      S_PUSH_JMP:  w = '{U_NOP,        C_ALWAYS,       S_VISIT};
      S_FOUND:     w = '{U_SET_FOUND,  C_ALWAYS,       S_EMIT};
      S_NOPATH:    w = '{U_SET_NOPATH, C_ALWAYS,       S_EMIT};
      S_SWEEP:     w = '{U_SWEEP_ALL,  C_NOT_LAST,     S_SWEEP};
      S_SWEEP_END: w = '{U_NOP,        C_ALWAYS,       S_IDLE};
      default:     w = '{U_NOP,        C_ALWAYS,       S_IDLE};
    endcase
    return w;
  endfunction

  // first step of each op's routine
  function automatic step_t dispatch(logic [1:0] op);
    step_t s;
    unique case (op)
      OP_WRITE:  s = S_WR0;
      OP_SEARCH: s = S_START;
      OP_READ:   s = S_RD0;
      OP_CLEAR:  s = S_CLR0;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/grid_maze_dfs_search_top.sv */
// grid maze depth-first search: microcoded sequencer, wall/visited/stack memories
// depends on gmdfs_pkg (types, control store, codes)
`default_nettype none

// Depth-first maze search on a 16x16 cell grid. One item is worked at a time; a
// result sits in an output register, so the next item is taken while it waits.
// Write walls reads the cell's wall entry and writes it back with the new bits
// ORed in; read path entry reads the stack and loads the result; clear sweeps the
// visited map, one visited entry per cycle, then empties the stack. A search loads
// and seeds the start, then for every cell the walk stands on visits it, probes each
// direction in turn and either takes and pushes a move or pops back to the cell
// below it on the stack; it reports found at the goal and no path when the walk
// ends on an empty or a full stack. After reset a sweep clears the wall and
// visited maps before the first item is taken. Moves stay within columns and rows
// 0..MAZE_DIM-1 (at most 15); the user must write goal_x and goal_y only while
// no item is in flight, as the block itself does not enforce it.
module grid_maze_dfs_search_top
  import gmdfs_pkg::*;
#(
  parameter int MAZE_DIM = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // op[1:0], cell_x[5:2], cell_y[9:6], wall_bits[13:10], path_index[21:14], zero fill
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], path_len[10:2], out_x[14:11], out_y[18:15], zero fill
  output logic      [23:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int CMAX_I = ((MAZE_DIM - 1) > 15) ? 15 : (MAZE_DIM - 1);
  localparam logic [4:0] COORD_MAX = 5'(CMAX_I);
  localparam logic [8:0] STACK_DEPTH = 9'd256;

  // sequencer
  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;
  logic       jump;

  // registers
  logic [3:0] goal_x;
  logic [3:0] goal_y;
  logic [8:0] stack_count;
  logic [7:0] sweep_addr;
  logic [7:0] current_cell;
  logic [1:0] dir;
  logic [7:0] here;
  logic [7:0] nb;
  logic       ok;
  logic [1:0] in_op;
  logic [3:0] in_x;
  logic [3:0] in_y;
  logic [3:0] in_walls;
  logic [7:0] in_idx;
  logic [1:0] res_status;
  logic [3:0] res_x;
  logic [3:0] res_y;
  logic       out_valid;
  logic [1:0] out_status;
  logic [8:0] out_len;
  logic [3:0] out_x;
  logic [3:0] out_y;

  // memories
  logic [3:0] wall_mem  [256];
  logic       vis_mem   [256];
  logic [7:0] stack_mem [256];
  logic [3:0] wall_rd;
  logic       vis_rd;
  logic [7:0] stk_rd;

  logic       wall_we, wall_re;
  logic [7:0] wall_waddr, wall_raddr;
  logic [3:0] wall_wdata;
  logic       vis_we, vis_re, vis_wdata;
  logic [7:0] vis_waddr;
  logic       stk_we, stk_re;
  logic [7:0] stk_waddr, stk_raddr;
  logic [7:0] stk_wdata;

  // datapath helpers
  logic       accept;
  logic       here_goal;
  logic       stack_full;
  logic       seed_en;
  logic       emit_en;
  logic [8:0] top_count;
  logic [4:0] px, py;
  logic [4:0] nx, ny;
  logic       wall_bit;
  logic [7:0] nb_cell;
  logic       move_ok;

  assign cw         = ucode(step);
  assign s_tready   = (cw.uop == U_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign here_goal  = (here == {goal_y, goal_x});
  assign stack_full = (stack_count >= STACK_DEPTH);
  assign seed_en    = (stack_count == 9'd0) && !here_goal;
  assign emit_en    = !out_valid || m_tready;
  assign top_count  = stack_count - 9'd1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_y, out_x, out_len, out_status};

  // neighbor of the current cell in the direction under test
  assign px = {1'b0, here[3:0]};
  assign py = {1'b0, here[7:4]};

  always_comb begin
    nx       = px;
    ny       = py;
    wall_bit = wall_rd[0];
    case (dir)
      DIR_N: begin ny = py + 5'd1; wall_bit = wall_rd[0]; end
      DIR_E: begin nx = px + 5'd1; wall_bit = wall_rd[1]; end
      DIR_S: begin ny = py - 5'd1; wall_bit = wall_rd[2]; end
      DIR_W: begin nx = px - 5'd1; wall_bit = wall_rd[3]; end
      default: begin nx = px; ny = py; wall_bit = 1'b1; end
    endcase
  end

  // stepping below zero wraps to 31, which also fails the bound check
  assign move_ok = (nx <= COORD_MAX) && (ny <= COORD_MAX) && !wall_bit;
  assign nb_cell = {ny[3:0], nx[3:0]};

  // jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:        jump = 1'b0;
      C_ALWAYS:       jump = 1'b1;
      C_OUT_BUSY:     jump = out_valid && !m_tready;
      C_NO_ACCEPT:    jump = !accept;
      C_DISPATCH:     jump = 1'b1;
      C_NOT_LAST:     jump = (sweep_addr != 8'hff);
      C_HERE_GOAL:    jump = here_goal;
      C_CAN_MOVE:     jump = ok && !vis_rd;
      C_NOT_LAST_DIR: jump = (dir != DIR_W);
      C_COUNT_ZERO:   jump = (stack_count == 9'd0);
      C_STACK_FULL:   jump = stack_full;
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    if (!jump) begin
      step_next = step + 5'd1;
    end else if (cw.cond == C_DISPATCH) begin
      step_next = dispatch(in_op);
    end else begin
      step_next = cw.target;
    end
  end

  // memory port control
  always_comb begin
    wall_we    = 1'b0;
    wall_waddr = sweep_addr;
    wall_wdata = 4'd0;
    wall_re    = 1'b0;
    wall_raddr = here;
    vis_we     = 1'b0;
    vis_waddr  = sweep_addr;
    vis_wdata  = 1'b0;
    vis_re     = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = stack_count[7:0];
    stk_wdata  = nb;
    stk_re     = 1'b0;
    stk_raddr  = in_idx;
    unique case (cw.uop)
      U_WALL_RD: begin
        wall_re    = 1'b1;
        wall_raddr = {in_y, in_x};
      end
      U_WALL_WR: begin
        wall_we    = 1'b1;
        wall_waddr = {in_y, in_x};
        wall_wdata = wall_rd | in_walls;
      end
      U_SWEEP_ALL: begin
        wall_we = 1'b1;
        vis_we  = 1'b1;
      end
      U_VIS_SWEEP: begin
        vis_we = 1'b1;
      end
      U_VISIT: begin
        wall_re   = 1'b1;
        vis_we    = !here_goal;
        vis_waddr = here;
        vis_wdata = 1'b1;
      end
      U_PROBE: begin
        vis_re = 1'b1;
      end
      U_SEED: begin
        stk_we    = seed_en;
        stk_waddr = 8'd0;
        stk_wdata = here;
      end
      U_PUSH: begin
        stk_we = !stack_full;
      end
      U_STK_RD_IDX: begin
        stk_re = 1'b1;
      end
      U_STK_RD_TOP: begin
        stk_re    = 1'b1;
        stk_raddr = top_count[7:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (wall_re) wall_rd <= wall_mem[wall_raddr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (vis_re) vis_rd <= vis_mem[nb_cell];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd <= stack_mem[stk_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= S_SWEEP;
      goal_x       <= 4'd7;
      goal_y       <= 4'd7;
      stack_count  <= 9'd0;
      sweep_addr   <= 8'd0;
      current_cell <= 8'd0;
      dir          <= DIR_N;
      out_valid    <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GOAL_X: goal_x <= cfg_wdata;
          CFG_GOAL_Y: goal_y <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cw.uop == U_EMIT && emit_en) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (cw.uop) inside
        U_IDLE:                   sweep_addr <= 8'd0;
        U_VIS_SWEEP, U_SWEEP_ALL: sweep_addr <= sweep_addr + 8'd1;
        U_CLEAR_STK:              stack_count <= 9'd0;
        U_SEED: begin
          if (seed_en) stack_count <= 9'd1;
        end
        U_VISIT: begin
          current_cell <= here;
          dir          <= DIR_N;
        end
        U_DIR_INC: dir <= dir + 2'd1;
        U_POP: begin
          if (stack_count != 9'd0) stack_count <= stack_count - 9'd1;
        end
        U_PUSH: begin
          if (!stack_full) stack_count <= stack_count + 9'd1;
        end
        U_SET_FOUND: current_cell <= here;
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cw.uop == U_IDLE && accept) begin
      in_op    <= s_tdata[1:0];
      in_x     <= s_tdata[5:2];
      in_y     <= s_tdata[9:6];
      in_walls <= s_tdata[13:10];
      in_idx   <= s_tdata[21:14];
    end
    if (cw.uop == U_EMIT && emit_en) begin
      out_status <= res_status;
      out_len    <= stack_count;
      out_x      <= res_x;
      out_y      <= res_y;
    end
    unique case (cw.uop)
      U_DECODE: begin
        res_x <= 4'd0;
        res_y <= 4'd0;
      end
      U_WALL_WR:    res_status <= ST_DONE;
      U_CLEAR_STK:  res_status <= ST_DONE;
      U_READ_OUT: begin
        res_status <= ST_READ;
        if ({1'b0, in_idx} < stack_count) begin
          res_x <= stk_rd[3:0];
          res_y <= stk_rd[7:4];
        end
      end
      U_LOAD_START: here <= {in_y, in_x};
      U_LOAD_TOP:   here <= stk_rd;
      U_PROBE: begin
        nb <= nb_cell;
        ok <= move_ok;
      end
      U_PUSH: begin
        if (!stack_full) here <= nb;
      end
      U_SET_FOUND:  res_status <= ST_FOUND;
      U_SET_NOPATH: res_status <= ST_NOPATH;
      default: begin
      end
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= STACK_DEPTH)
    else $error("path stack count beyond depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item taken while one is in work");

  a_walk_stack: assert property (@(posedge clk) disable iff (rst)
    (step == S_VISIT) |-> (stack_count != 9'd0))
    else $error("walk visits a cell with an empty stack");

  a_found_goal: assert property (@(posedge clk) disable iff (rst)
    (step == S_FOUND) |=> (current_cell == {goal_y, goal_x}))
    else $error("found reported away from the goal cell");

endmodule

`default_nettype wire
